### hw/rtl/sit_pkg.sv
// sit_pkg: shared types, constants and status codes for sorted_interval_table.
// No dependencies.
`default_nettype none
package sit_pkg;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned MaxPieces  = 16;
  localparam int unsigned PcW        = $clog2(MaxPieces + 1);
  localparam int unsigned QDepth     = 2;

  localparam logic       OpInsert = 1'b0;
  localparam logic       OpClip   = 1'b1;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StOverlap  = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StInvalid  = 3'd3;
  localparam logic [2:0] StPiece    = 3'd4;
  localparam logic [2:0] StNothing  = 3'd5;

  typedef struct packed {
    logic        operation;
    logic [31:0] range_from;
    logic [31:0] range_to;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] piece_from;
    logic [31:0] piece_to;
    logic [31:0] covered_total;
    logic        last;
  } result_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic        invalid;
    logic        operation;
    logic [31:0] range_from;
    logic [31:0] range_to;
  } cmd_t;
endpackage
`default_nettype wire

### hw/rtl/sit_if.sv
// sit_if: valid/ready channel carrying one beat of a given payload type.
// Depends on sit_pkg for the payload types.
`default_nettype none
interface sit_in_if;
  logic          valid;
  logic          ready;
  sit_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sit_out_if;
  logic            valid;
  logic            ready;
  sit_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/sit_front.sv
// sit_front: accepts input beats, flags reversed ranges, queues commands.
// Depends on sit_pkg.
`default_nettype none
module sit_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sit_pkg::item_t in_data_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output sit_pkg::cmd_t      cmd_o
);
  sit_pkg::cmd_t mem_q [sit_pkg::QDepth];
  logic          wp_q, wp_d, rp_q, rp_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  assign in_ready_o  = (cnt_q != 2'(sit_pkg::QDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].invalid    <= in_data_i.range_from > in_data_i.range_to;
      mem_q[wp_q].operation  <= in_data_i.operation;
      mem_q[wp_q].range_from <= in_data_i.range_from;
      mem_q[wp_q].range_to   <= in_data_i.range_to;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/sit_back.sv
// sit_back: walks the range table for insert and clip commands, drives results.
// Depends on sit_pkg.
`default_nettype none
module sit_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire sit_pkg::cmd_t cmd_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sit_pkg::result_t   out_data_o
);
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SIns   = 3'd1;
  localparam logic [2:0] SShift = 3'd2;
  localparam logic [2:0] SClip  = 3'd3;
  localparam logic [2:0] SEmit  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [31:0] st_q [sit_pkg::TableDepth];
  logic [31:0] en_q [sit_pkg::TableDepth];
  logic [sit_pkg::CntW-1:0] count_q;
  logic [31:0] total_q;
  sit_pkg::cmd_t cmd_q;
  logic [sit_pkg::CntW-1:0] i_q, j_q;
  logic [sit_pkg::PcW-1:0]  n_q;
  logic        ov_q;
  sit_pkg::result_t res_q;
  sit_pkg::result_t pend_q;
  logic [31:0] s_cur, e_cur;
  logic [sit_pkg::IdxW-1:0] ri, jm1, jix, lix;
  logic        obusy;

  assign ri    = i_q[sit_pkg::IdxW-1:0];
  assign s_cur = st_q[ri];
  assign e_cur = en_q[ri];
  assign jix   = j_q[sit_pkg::IdxW-1:0];
  assign jm1   = jix - 1'b1;
  assign lix   = count_q[sit_pkg::IdxW-1:0] - 1'b1;
  assign obusy = ov_q && !out_ready_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;
  assign cmd_ready_o = (state_q == SIdle) && !obusy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      total_q <= '0;
      ov_q    <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (cmd_valid_i && !obusy) begin
            cmd_q <= cmd_i;
            i_q   <= '0;
            n_q   <= '0;
            if (cmd_i.invalid) begin
              res_q <= '{sit_pkg::StInvalid, 32'd0, 32'd0, total_q, 1'b1};
              ov_q  <= 1'b1;
            end else if (cmd_i.operation == sit_pkg::OpClip) begin
              state_q <= SClip;
            end else if (count_q == sit_pkg::CntW'(sit_pkg::TableDepth)) begin
              res_q <= '{sit_pkg::StFull, 32'd0, 32'd0, total_q, 1'b1};
              ov_q  <= 1'b1;
            end else if (count_q == '0 || en_q[lix] <= cmd_i.range_from) begin
              st_q[count_q[sit_pkg::IdxW-1:0]] <= cmd_i.range_from;
              en_q[count_q[sit_pkg::IdxW-1:0]] <= cmd_i.range_to;
              count_q <= count_q + 1'b1;
              total_q <= total_q + (cmd_i.range_to - cmd_i.range_from);
              res_q <= '{sit_pkg::StInserted, 32'd0, 32'd0,
                         total_q + (cmd_i.range_to - cmd_i.range_from), 1'b1};
              ov_q  <= 1'b1;
            end else begin
              state_q <= SIns;
            end
          end
        end
        SIns: begin
          if (i_q == count_q || (s_cur < cmd_q.range_to && cmd_q.range_from < e_cur)) begin
            res_q   <= '{sit_pkg::StOverlap, 32'd0, 32'd0, total_q, 1'b1};
            ov_q    <= 1'b1;
            state_q <= SIdle;
          end else if (cmd_q.range_to <= s_cur) begin
            j_q     <= count_q;
            state_q <= SShift;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        SShift: begin
          // move one entry up per cycle, then drop the new range in place
          if (j_q == i_q) begin
            st_q[ri] <= cmd_q.range_from;
            en_q[ri] <= cmd_q.range_to;
            count_q  <= count_q + 1'b1;
            total_q  <= total_q + (cmd_q.range_to - cmd_q.range_from);
            res_q <= '{sit_pkg::StInserted, 32'd0, 32'd0,
                       total_q + (cmd_q.range_to - cmd_q.range_from), 1'b1};
            ov_q    <= 1'b1;
            state_q <= SIdle;
          end else begin
            st_q[jix] <= st_q[jm1];
            en_q[jix] <= en_q[jm1];
            j_q <= j_q - 1'b1;
          end
        end
        SClip: begin
          if (!obusy) begin
            if (i_q == count_q || n_q == sit_pkg::PcW'(sit_pkg::MaxPieces)
                || cmd_q.range_to <= s_cur) begin
              // finish: send the held piece marked last, or report nothing
              if (n_q == '0) begin
                res_q <= '{sit_pkg::StNothing, 32'd0, 32'd0, total_q, 1'b1};
                ov_q  <= 1'b1;
                state_q <= SIdle;
              end else begin
                res_q      <= '{pend_q.status, pend_q.piece_from, pend_q.piece_to,
                                pend_q.covered_total, 1'b1};
                ov_q       <= 1'b1;
                state_q    <= SIdle;
              end
            end else if (e_cur <= cmd_q.range_from) begin
              i_q <= i_q + 1'b1;
            end else begin
              // hold the piece until we know whether another follows;
              // the one held before goes out now
              if (n_q != '0) begin
                res_q <= pend_q;
                ov_q  <= 1'b1;
              end
              pend_q <= '{sit_pkg::StPiece,
                          (s_cur > cmd_q.range_from) ? s_cur : cmd_q.range_from,
                          (e_cur < cmd_q.range_to) ? e_cur : cmd_q.range_to,
                          total_q, 1'b0};
              i_q <= i_q + 1'b1;
              n_q <= n_q + 1'b1;
              state_q <= SEmit;
            end
          end
        end
        SEmit: begin
          state_q <= SClip;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/sorted_interval_table.sv
// sorted_interval_table: top level, joins the front queue and the table walker.
// Depends on sit_pkg, sit_if, sit_front, sit_back.
// A sorted table of up to 16 disjoint half-open ranges [from,to) with a running
// covered total. An insert that lands after the last entry answers in the cycle
// after the walker takes it; otherwise the walker scans one entry per cycle up
// to the slot, then shifts one entry per cycle to open it. A clip walks the
// entries in order, emits at most 16 pieces and waits while the output stalls.
// Pieces are sent one beat behind the walk so the final beat carries last.
// Rate is set by the single table walker; a two-deep command queue lets new
// beats be taken while the walker is busy.
`default_nettype none
module sorted_interval_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sit_in_if.sink    in_if,
  sit_out_if.source out_if
);
  logic          cmd_valid, cmd_ready;
  sit_pkg::cmd_t cmd;

  sit_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  sit_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );
endmodule
`default_nettype wire

### hw/rtl/sit_checker.sv
// sit_checker: port-level assertions for sorted_interval_table, bound in.
// Depends on sit_pkg, sit_if.
`default_nettype none
module sit_port_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire sit_pkg::result_t out_data_i
);
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.status <= sit_pkg::StNothing) else $error("bad status");
  a_piece_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != sit_pkg::StPiece |->
      out_data_i.piece_from == 32'd0 && out_data_i.piece_to == 32'd0 && out_data_i.last)
    else $error("non-piece result malformed");
  a_piece_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == sit_pkg::StPiece |->
      out_data_i.piece_from <= out_data_i.piece_to) else $error("reversed piece");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("beat dropped");
endmodule

bind sorted_interval_table sit_port_checker u_sit_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);
`default_nettype wire

### bench/sit_checker.sv
// sit_checker: watches both channels of sorted_interval_table, predicts results, compares.
// Depends on sit_pkg and sit_if.
module sit_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  sit_in_if.sink    in_mon,
  sit_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending_count
);
  import sit_pkg::*;

  logic [31:0] tbl_from [TableDepth];
  logic [31:0] tbl_to   [TableDepth];
  int unsigned tbl_count;
  logic [31:0] covered;
  result_t     expected_q[$];

  assign pending_count = expected_q.size();

  task automatic report(input string what, input result_t got, input result_t want);
    $display("mismatch %s: got st=%0d %h..%h tot=%h last=%b want st=%0d %h..%h tot=%h last=%b",
             what, got.status, got.piece_from, got.piece_to, got.covered_total, got.last,
             want.status, want.piece_from, want.piece_to, want.covered_total, want.last);
    fail_count++;
  endtask

  function automatic logic [2:0] insert_range(input logic [31:0] f, input logic [31:0] t);
    int unsigned i, j;
    if (f > t) return StInvalid;
    if (tbl_count >= TableDepth) return StFull;
    if (tbl_count == 0 || tbl_to[tbl_count-1] <= f) begin
      tbl_from[tbl_count] = f;
      tbl_to[tbl_count] = t;
      tbl_count++;
      covered += t - f;
      return StInserted;
    end
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_from[i] < t && f < tbl_to[i]) return StOverlap;
      if (t <= tbl_from[i]) begin
        for (j = tbl_count; j > i; j--) begin
          tbl_from[j] = tbl_from[j-1];
          tbl_to[j] = tbl_to[j-1];
        end
        tbl_from[i] = f;
        tbl_to[i] = t;
        tbl_count++;
        covered += t - f;
        return StInserted;
      end
    end
    return StOverlap;
  endfunction

  task automatic predict_item(input item_t it);
    result_t r;
    int unsigned i, n;
    r = '0;
    if (it.operation == OpInsert) begin
      r.status = insert_range(it.range_from, it.range_to);
      r.covered_total = covered;
      r.last = 1'b1;
      expected_q = {expected_q, r};
    end else if (it.range_from > it.range_to) begin
      r.status = StInvalid;
      r.covered_total = covered;
      r.last = 1'b1;
      expected_q = {expected_q, r};
    end else begin
      n = 0;
      for (i = 0; i < tbl_count && n < MaxPieces; i++) begin
        if (tbl_to[i] <= it.range_from) continue;
        if (it.range_to <= tbl_from[i]) break;
        r.status = StPiece;
        r.piece_from = tbl_from[i] > it.range_from ? tbl_from[i] : it.range_from;
        r.piece_to = tbl_to[i] < it.range_to ? tbl_to[i] : it.range_to;
        r.covered_total = covered;
        r.last = 1'b0;
        expected_q = {expected_q, r};
        n++;
      end
      if (n == 0) begin
        r = '0;
        r.status = StNothing;
        r.covered_total = covered;
        r.last = 1'b1;
        expected_q = {expected_q, r};
      end else begin
        expected_q[$].last = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      tbl_count = 0;
      covered = '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) predict_item(in_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          want = '0;
          report("unexpected beat", out_mon.data, want);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.data.status !== want.status) report("status", out_mon.data, want);
          else if (out_mon.data.piece_from !== want.piece_from)
            report("piece_from", out_mon.data, want);
          else if (out_mon.data.piece_to !== want.piece_to)
            report("piece_to", out_mon.data, want);
          else if (out_mon.data.covered_total !== want.covered_total)
            report("covered_total", out_mon.data, want);
          else if (out_mon.data.last !== want.last) report("last", out_mon.data, want);
        end
      end
    end
  end
endmodule

### bench/tb_sorted_interval_table.sv
// tb_sorted_interval_table: stimulus, stalls and verdict for sorted_interval_table.
// Depends on sit_pkg, sit_if, sit_checker and the block's RTL.
module tb_sorted_interval_table;
  import sit_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending_count;
  int   idle_cycles;
  bit   sink_stalls = 1'b1;  // random ready bursts on the output side
  bit   hold_sink   = 1'b0;  // long receiver hold-off, cleared by the receiver
  bit   done_flag   = 1'b0;

  sit_in_if  in_if();
  sit_out_if out_if();

  sorted_interval_table dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if));
  sit_checker chk (.clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_if), .out_mon(out_if),
                   .fail_count(fail_count), .pending_count(pending_count));

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // Receiver: ready bursts, or a long hold-off when hold_sink is set.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_sink = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        n = $urandom_range(1, 4);
        repeat (n - 1) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles without any accepted beat.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || hold_sink)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000 && !done_flag) begin
      $display("sorted_interval_table regression: fail");
      $finish;
    end
  end

  // Send one beat; optional random gap before it. Valid stays high across back-to-back beats.
  task automatic send_beat(input logic op, input logic [31:0] f, input logic [31:0] t,
                           input bit gaps);
    int n;
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= {op, f, t};
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Random item: mostly small ranges in a narrow window so inserts land and clips hit.
  task automatic random_item(input bit gaps);
    logic        op;
    logic [31:0] base, f, t;
    op = ($urandom_range(0, 2) == 0) ? OpClip : OpInsert;
    base = ($urandom_range(0, 9) == 0) ? $urandom : 32'h0000_1000;
    f = base + $urandom_range(0, 400);
    t = f + $urandom_range(0, 40);
    if (op == OpClip) t = f + $urandom_range(0, 300);
    if ($urandom_range(0, 15) == 0) begin
      f = $urandom;
      t = $urandom;
    end
    send_beat(op, f, t, gaps);
  endtask

  initial begin
    int k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table clip, reversed ranges, empty range, extremes, prepend, middle.
    send_beat(OpClip, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_beat(OpInsert, 32'h10, 32'h5, 1'b0);
    send_beat(OpClip, 32'h10, 32'h5, 1'b0);
    send_beat(OpInsert, 32'h100, 32'h200, 1'b0);
    send_beat(OpInsert, 32'h300, 32'h300, 1'b0);
    send_beat(OpInsert, 32'h0, 32'h50, 1'b0);
    send_beat(OpInsert, 32'h60, 32'h80, 1'b0);
    send_beat(OpInsert, 32'h150, 32'h160, 1'b0);
    send_beat(OpInsert, 32'h200, 32'h200, 1'b0);
    send_beat(OpInsert, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
    send_beat(OpInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_beat(OpClip, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_beat(OpClip, 32'h40, 32'h150, 1'b0);
    send_beat(OpClip, 32'h90, 32'h90, 1'b0);
    send_beat(OpClip, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    // Fill the table and push past it; then clip across the full table.
    for (k = 0; k < 12; k++) send_beat(OpInsert, 32'h1000 + k * 16, 32'h1008 + k * 16, 1'b0);
    send_beat(OpInsert, 32'hAAAA_5555, 32'h5555_AAAA, 1'b0);
    send_beat(OpClip, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_beat(OpClip, 32'h1004, 32'h1044, 1'b0);
    drain_results();

    // Long receiver hold-off while the sender keeps offering beats.
    hold_sink = 1'b1;
    for (k = 0; k < 10; k++) send_beat(OpClip, 32'h0, 32'hFFFF_FFFF, 1'b0);
    drain_results();

    // Random phase with idling on both sides. The table is full after the
    // directed part, so random inserts mostly get status 2; clips keep
    // exercising the stored set.
    for (k = 0; k < 90; k++) random_item(1'b1);
    drain_results();
    // Closing part: no idling.
    sink_stalls = 1'b0;
    for (k = 0; k < 30; k++) random_item(1'b0);
    drain_results();

    done_flag = 1'b1;
    if (fail_count == 0)
      $display("sorted_interval_table regression: pass");
    else
      $display("sorted_interval_table regression: fail");
    $finish;
  end
endmodule
